// File: rtl/rpn_pkg.sv
// rpn_pkg: command codes, status codes and result types shared by the
// RPN stack calculator modules. No dependencies.
package rpn_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Command codes carried by the kind field
	typedef enum logic [2:0] {
		KIND_PUSH = 3'd0,
		KIND_ADD  = 3'd1,
		KIND_SUB  = 3'd2,
		KIND_MUL  = 3'd3,
		KIND_PEEK = 3'd4
	} kind_t;

	// Status codes reported with every result
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FEW   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Result of one step, depth travels beside it (its width is parameterized)
	typedef struct packed {
		status_t status;
		word_t   top;
	} result_t;

endpackage

// File: rtl/rpn_alu.sv
// rpn_alu: wrapping 32-bit add, subtract and multiply on the two top entries.
// Depends on rpn_pkg.
module rpn_alu (
	input  rpn_pkg::kind_t kind,
	input  rpn_pkg::word_t second,
	input  rpn_pkg::word_t top,
	output rpn_pkg::word_t res
);

	// Second minus top for subtract; low 32 bits of the product for multiply
	always_comb begin
		unique case (kind)
			rpn_pkg::KIND_ADD: res = second + top;
			rpn_pkg::KIND_SUB: res = second - top;
			rpn_pkg::KIND_MUL: res = second * top;
			default:           res = second + top;
		endcase
	end

endmodule

// File: rtl/rpn_stack.sv
// rpn_stack: stack state. Top and second entries sit in registers, deeper
// entries in a memory with a registered read of the third entry.
// Depends on rpn_pkg and rpn_alu.
module rpn_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int CW          = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  rpn_pkg::kind_t       kind,
	input  rpn_pkg::word_t       push_value,
	output rpn_pkg::result_t     res_next,
	output logic [CW-1:0]        depth_next
);

	localparam int MEM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [CW-1:0]           fill_q;
	rpn_pkg::word_t          top_q;
	rpn_pkg::word_t          second_q;
	rpn_pkg::word_t          mem [MEM_DEPTH];
	rpn_pkg::word_t          rd_q;
	rpn_pkg::word_t          byp_q;
	logic                    byp_sel_q;

	rpn_pkg::word_t          third;
	rpn_pkg::word_t          alu_res;
	rpn_pkg::word_t          ntop;
	rpn_pkg::word_t          nsec;
	logic [CW-1:0]           nfill;
	logic [CW-1:0]           rd_full;
	logic [CW-1:0]           wr_full;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           waddr;
	rpn_pkg::status_t        status;
	logic                    spill;
	logic                    we;

	rpn_alu u_alu (
		.kind   (kind),
		.second (second_q),
		.top    (top_q),
		.res    (alu_res)
	);

	// Third entry: memory read data, or the word written there last cycle
	assign third = byp_sel_q ? byp_q : rd_q;

	// Next state for one command
	always_comb begin
		nfill  = fill_q;
		ntop   = top_q;
		nsec   = second_q;
		status = rpn_pkg::ST_OK;
		spill  = 1'b0;
		unique case (kind)
			rpn_pkg::KIND_PUSH: begin
				if (fill_q >= CW'(STACK_DEPTH)) begin
					status = rpn_pkg::ST_FULL;
				end else begin
					nfill = fill_q + CW'(1);
					ntop  = push_value;
					nsec  = top_q;
					spill = (fill_q >= CW'(2));
				end
			end
			rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL: begin
				if (fill_q < CW'(2)) begin
					status = rpn_pkg::ST_FEW;
				end else begin
					nfill = fill_q - CW'(1);
					ntop  = alu_res;
					nsec  = third;
				end
			end
			rpn_pkg::KIND_PEEK: begin
				if (fill_q == '0) begin
					status = rpn_pkg::ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Memory addresses: spill second into entry fill-2, prefetch entry fill-3
	assign we      = accept && spill;
	assign wr_full = fill_q - CW'(2);
	assign waddr   = wr_full[AW-1:0];
	assign rd_full = (accept ? nfill : fill_q) - CW'(3);
	assign raddr   = rd_full[AW-1:0];

	// Result as seen after this command
	assign res_next.status = status;
	assign res_next.top    = (nfill == '0) ? '0 : ntop;
	assign depth_next      = nfill;

	// Fill count and bypass select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			byp_sel_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= nfill;
			end
			byp_sel_q <= we && (waddr == raddr);
		end
	end

	// Cached top entries and bypass word
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= ntop;
			second_q <= nsec;
		end
		byp_q <= second_q;
	end

	// Deeper entries
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= second_q;
		end
		rd_q <= mem[raddr];
	end

endmodule

// File: rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: top level, handshake and result register.
// Depends on rpn_pkg and rpn_stack.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   command  | in_valid, in_stall, kind, push_value     | in
//   result   | out_valid, out_stall, status, top_value, | out
//            | depth                                    |
//
// One item per cycle unless stalled; its result is valid in the next cycle.
// The third entry is prefetched from the stack memory every cycle, with a
// bypass for the word spilled in the cycle before, so operations never wait.
// Reset empties the stack at once; no clearing pass is needed.
// A stalled result holds the command channel in stall until it is taken.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic signed [31:0]   push_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic signed [31:0]   top_value,
	output logic [$clog2(STACK_DEPTH + 1)-1:0] depth
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic                  accept;
	logic                  out_valid_q;
	rpn_pkg::result_t      res_next;
	rpn_pkg::result_t      res_q;
	logic [CW-1:0]         depth_next;
	logic [CW-1:0]         depth_q;

	// Take a new item whenever the result slot is empty or being drained
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	rpn_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.CW          (CW)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (rpn_pkg::kind_t'(kind)),
		.push_value (push_value),
		.res_next   (res_next),
		.depth_next (depth_next)
	);

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept || (out_valid_q && out_stall);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q   <= res_next;
			depth_q <= depth_next;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign top_value = res_q.top;
	assign depth     = depth_q;

`ifndef SYNTHESIS
	// Depth never passes the configured size
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (depth <= CW'(STACK_DEPTH)))
		else $error("depth above stack size");

	// Empty report means nothing on the stack and a zero top
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rpn_pkg::ST_EMPTY) |-> (depth == '0 && top_value == '0))
		else $error("empty status with entries");

	// Full report only when the stack is full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rpn_pkg::ST_FULL) |-> (depth == CW'(STACK_DEPTH)))
		else $error("full status below stack size");

	// An accepted push that succeeds shows the pushed value on top
	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == rpn_pkg::KIND_PUSH && depth_next != CW'(0)
			&& res_next.status == rpn_pkg::ST_OK)
		|=> (out_valid && top_value == $past(push_value)))
		else $error("pushed value not on top");
`endif

endmodule

// File: test/tb.sv
// tb: self-checking testbench for rpn_stack_calculator. It drives commands and
// checks every result against a stack predictor or a typed row's expected result.
// Depends on rpn_pkg and the rpn_stack_calculator RTL.
module tb;

	localparam int STACK_DEPTH = 64;
	localparam int CW          = $clog2(STACK_DEPTH + 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 250;
	localparam int HOLD_CYCLES = 300;

	// kind codes the block leaves unused
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef struct packed {
		rpn_pkg::status_t st;
		rpn_pkg::word_t   top;
		logic [CW-1:0]    dep;
	} calc_result_t;

	typedef struct packed {
		logic [2:0]      k;
		rpn_pkg::word_t  v;
		logic            typed;
		calc_result_t    res;
	} cmd_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          kind;
	logic signed [31:0]  push_value;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic signed [31:0]  top_value;
	logic [CW-1:0]       depth;

	rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.top_value(top_value),
		.depth(depth)
	);

	// predictor state
	rpn_pkg::word_t stack_img [STACK_DEPTH];
	int             stack_fill;
	calc_result_t   pending_results [$];

	int             mismatches;
	int             cycle_count;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             hold_req;

	// directed commands; typed rows carry their expected result
	cmd_row_t dir_rows [25] = '{
		'{rpn_pkg::KIND_PEEK, 32'sh0,        1'b1, '{rpn_pkg::ST_EMPTY, 32'sh0,        7'd0}},
		'{rpn_pkg::KIND_ADD,  32'sh0,        1'b1, '{rpn_pkg::ST_FEW,   32'sh0,        7'd0}},
		'{rpn_pkg::KIND_MUL,  32'sh0,        1'b1, '{rpn_pkg::ST_FEW,   32'sh0,        7'd0}},
		'{rpn_pkg::KIND_PUSH, 32'sh7fffffff, 1'b1, '{rpn_pkg::ST_OK, 32'sh7fffffff, 7'd1}},
		'{rpn_pkg::KIND_SUB,  32'sh0,        1'b1, '{rpn_pkg::ST_FEW, 32'sh7fffffff, 7'd1}},
		'{rpn_pkg::KIND_PUSH, 32'sh1,        1'b1, '{rpn_pkg::ST_OK,    32'sh1,        7'd2}},
		'{rpn_pkg::KIND_ADD,  32'sh0,        1'b1, '{rpn_pkg::ST_OK, 32'sh80000000, 7'd1}},
		'{rpn_pkg::KIND_PUSH, 32'sh80000000, 1'b1, '{rpn_pkg::ST_OK, 32'sh80000000, 7'd2}},
		'{rpn_pkg::KIND_SUB,  32'sh0,        1'b1, '{rpn_pkg::ST_OK,    32'sh0,        7'd1}},
		'{rpn_pkg::KIND_PUSH, 32'shffffffff, 1'b1, '{rpn_pkg::ST_OK, 32'shffffffff, 7'd2}},
		'{rpn_pkg::KIND_MUL,  32'sh0,        1'b1, '{rpn_pkg::ST_OK,    32'sh0,        7'd1}},
		'{rpn_pkg::KIND_PUSH, 32'sh3,        1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_PUSH, 32'sh5,        1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_SUB,  32'sh0,        1'b1, '{rpn_pkg::ST_OK, 32'shfffffffe, 7'd2}},
		'{KIND_RSVD5,         32'shffffffff, 1'b1, '{rpn_pkg::ST_OK, 32'shfffffffe, 7'd2}},
		'{KIND_RSVD6,         32'sh5a5a5a5a, 1'b1, '{rpn_pkg::ST_OK, 32'shfffffffe, 7'd2}},
		'{KIND_RSVD7,         32'sh7fffffff, 1'b1, '{rpn_pkg::ST_OK, 32'shfffffffe, 7'd2}},
		'{rpn_pkg::KIND_PEEK, 32'sh12345678, 1'b1, '{rpn_pkg::ST_OK, 32'shfffffffe, 7'd2}},
		'{rpn_pkg::KIND_PUSH, 32'sh00010000, 1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_PUSH, 32'sh00010000, 1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_MUL,  32'sh0,        1'b1, '{rpn_pkg::ST_OK,    32'sh0,        7'd3}},
		'{rpn_pkg::KIND_PUSH, 32'shffffffff, 1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_PUSH, 32'shffffffff, 1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_MUL,  32'sh0,        1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}},
		'{rpn_pkg::KIND_ADD,  32'sh0,        1'b0, '{rpn_pkg::ST_OK,    32'sh0,        7'd0}}
	};

	// one step of the stack: updates the image, returns the result
	function automatic calc_result_t calc_step(logic [2:0] k, rpn_pkg::word_t v);
		calc_result_t   r;
		rpn_pkg::word_t tos;
		rpn_pkg::word_t nos;
		logic [31:0]    acc;
		r.st = rpn_pkg::ST_OK;
		case (k)
			rpn_pkg::KIND_PUSH: begin
				if (stack_fill >= STACK_DEPTH) begin
					r.st = rpn_pkg::ST_FULL;
				end else begin
					stack_img[stack_fill] = v;
					stack_fill++;
				end
			end
			rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL: begin
				if (stack_fill < 2) begin
					r.st = rpn_pkg::ST_FEW;
				end else begin
					tos = stack_img[stack_fill-1];
					nos = stack_img[stack_fill-2];
					if (k == rpn_pkg::KIND_ADD)
						acc = nos + tos;
					else if (k == rpn_pkg::KIND_SUB)
						acc = nos - tos;
					else
						acc = nos * tos;
					stack_fill--;
					stack_img[stack_fill-1] = acc;
				end
			end
			rpn_pkg::KIND_PEEK: begin
				if (stack_fill == 0)
					r.st = rpn_pkg::ST_EMPTY;
			end
			default: ;
		endcase
		r.top = (stack_fill == 0) ? '0 : stack_img[stack_fill-1];
		r.dep = CW'(stack_fill);
		return r;
	endfunction

	// offer one item, wait for acceptance, queue its expected result
	task automatic issue_cmd(cmd_row_t row);
		calc_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= row.k;
		push_value <= row.v;
		do @(posedge clk); while (in_stall);
		r = calc_step(row.k, row.v);
		pending_results.push_back(row.typed ? row.res : r);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stall, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		calc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d top %h depth %0d",
						status, top_value, depth);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || top_value !== e.top || depth !== e.dep) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d top %h dep %0d, got st %0d top %h dep %0d",
							e.st, e.top, e.dep, status, top_value, depth);
				end
			end
		end
	end

	// stimulus
	initial begin
		cmd_row_t    row;
		int          counted;
		int          mode;
		int          mode_left;
		int          push_pct;
		int          pick;
		int          phase;

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		stack_fill     = 0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		kind          <= rpn_pkg::KIND_PEEK;
		push_value    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_rows[i])
			issue_cmd(dir_rows[i]);

		// random part: four idling phases
		mode_left = 0;
		mode      = 0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				// long result hold-off while commands keep coming
				if (phase == 0 && counted == 60)
					hold_req = HOLD_CYCLES;
				// grow, shrink or mixed stretches move the stack depth around
				if (mode_left == 0) begin
					mode      = $urandom_range(2);
					mode_left = $urandom_range(30, 150);
				end
				mode_left--;
				push_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
				pick = $urandom_range(99);
				row.typed = 1'b0;
				row.res   = '0;
				if (pick < 3)
					row.k = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
				else if (pick < 11)
					row.k = rpn_pkg::KIND_PEEK;
				else if (pick < 11 + push_pct)
					row.k = rpn_pkg::KIND_PUSH;
				else
					row.k = 3'($urandom_range(rpn_pkg::KIND_ADD, rpn_pkg::KIND_MUL));
				case ($urandom_range(9))
					0: row.v = 32'sh7fffffff;
					1: row.v = 32'sh80000000;
					2: row.v = '0;
					3: row.v = -32'sd1;
					4: row.v = $urandom_range(20);
					5: row.v = -$signed(32'($urandom_range(20)));
					default: row.v = $urandom;
				endcase
				issue_cmd(row);
				if (row.k < KIND_RSVD5)
					counted++;
			end
			// sender pauses until every result is back
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
